FILE: src/stream_block_reverser_assert.svh
// Assertion macros shared by the stream block reverser RTL.
`ifndef STREAM_BLOCK_REVERSER_ASSERT_SVH
`define STREAM_BLOCK_REVERSER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SBR_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stream_block_reverser: assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SBR_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stream_block_reverser: assertion failed");

`endif

FILE: src/sbr_pkg.sv
// Package of shared constants for the stream block reverser.
package sbr_pkg;

   // payload width of one stream value
   localparam int DATA_W = 32;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int GS_W       = 5;

   // register index of group_size (byte address 4 * index)
   localparam logic [CSR_ADDR_W-3:0] REG_GROUP_SIZE = 1'b0;

endpackage

FILE: src/stream_block_reverser.sv
// Stream block reverser: reverses full groups of group_size items; a short final group keeps order.
// Items are taken one per cycle while a group fills; the transfer that closes a
// group (or ends the stream) starts a readout of the group store.
// Reads go through the store's single registered read port and a pending stage
// into the output register, one result per cycle unless the output stalls; input
// is stalled until the group is drained. Reset: fill count 0, group_size 1,
// output empty; store contents are not cleared and no clearing pass is run.
module stream_block_reverser
   import sbr_pkg::*;
#(
   parameter int MAX_GROUP = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [DATA_W-1:0]  req_item_value,
   input  logic                      req_stream_end,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [DATA_W-1:0]  rsp_out_value,
   output logic                      rsp_last_of_run,
   output logic                      rsp_out_stream_end,
   // configuration port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_W-1:0]     paddr,
   input  logic [CSR_DATA_W-1:0]     pwdata,
   output logic [CSR_DATA_W-1:0]     prdata,
   output logic                      pready
);

   `include "stream_block_reverser_assert.svh"

   localparam int IDX_W  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int FILL_W = $clog2(MAX_GROUP + 1);
   localparam int K_W    = (FILL_W > GS_W) ? FILL_W : GS_W;

   localparam logic ST_FILL  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic              state_ff, state_in;
   logic [GS_W-1:0]   group_size_ff, group_size_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] n_ff, n_in;
   logic [FILL_W-1:0] cnt_ff, cnt_in;
   logic              rev_ff, rev_in;
   logic              end_ff, end_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;
   logic              pend_end_ff, pend_end_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_end_ff, rsp_end_in;

   logic              csr_write;
   logic              csr_hit;
   logic [K_W-1:0]    gs_ext;
   logic [K_W-1:0]    k_eff;
   logic [FILL_W-1:0] fill_next;
   logic              group_full;
   logic              req_xfer;
   logic              out_free;
   logic              issue;
   logic              move;
   logic [FILL_W-1:0] rd_pos;
   logic signed [DATA_W-1:0] ram_q;

   // configuration register
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[CSR_ADDR_W-1:2] == REG_GROUP_SIZE);
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = csr_hit ? CSR_DATA_W'(group_size_ff) : '0;

   always_comb begin
      group_size_in = group_size_ff;
      if (csr_write && csr_hit) begin
         group_size_in = pwdata[GS_W-1:0];
      end
   end

   // effective group size: zero reads as one, saturate at the store depth
   always_comb begin
      gs_ext = K_W'(group_size_ff);
      k_eff  = gs_ext;
      if (gs_ext == '0) begin
         k_eff = K_W'(1);
      end else if (gs_ext > K_W'(MAX_GROUP)) begin
         k_eff = K_W'(MAX_GROUP);
      end
   end

   assign fill_next  = fill_ff + FILL_W'(1);
   assign group_full = (K_W'(fill_next) >= k_eff);
   assign req_stall  = (state_ff != ST_FILL);
   assign req_xfer   = req_valid && !req_stall;

   // readout handshake
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign move     = pend_ff && out_free;
   assign issue    = (state_ff == ST_DRAIN) && (cnt_ff != n_ff) && (!pend_ff || out_free);
   assign rd_pos   = rev_ff ? (n_ff - FILL_W'(1) - cnt_ff) : cnt_ff;

   sbr_group_ram #(
      .DEPTH (MAX_GROUP),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (req_item_value),
      .rd_en   (issue),
      .rd_addr (rd_pos[IDX_W-1:0]),
      .rd_data (ram_q)
   );

   // sequencer: fill a group, then drain it
   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      rev_in   = rev_ff;
      end_in   = end_ff;
      case (state_ff)
         ST_FILL: begin
            if (req_xfer) begin
               if (group_full || req_stream_end) begin
                  state_in = ST_DRAIN;
                  fill_in  = '0;
                  n_in     = fill_next;
                  cnt_in   = '0;
                  rev_in   = group_full;
                  end_in   = req_stream_end;
               end else begin
                  fill_in = fill_next;
               end
            end
         end
         ST_DRAIN: begin
            if (issue) begin
               cnt_in = cnt_ff + FILL_W'(1);
            end
            if ((cnt_ff == n_ff) && (!pend_ff || out_free)) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // read in flight, tagged with its flags
   always_comb begin
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      pend_end_in  = pend_end_ff;
      if (issue) begin
         pend_in      = 1'b1;
         pend_last_in = (cnt_ff + FILL_W'(1) == n_ff);
         pend_end_in  = (cnt_ff + FILL_W'(1) == n_ff) && end_ff;
      end else if (move) begin
         pend_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = ram_q;
         rsp_last_in  = pend_last_ff;
         rsp_end_in   = pend_end_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         group_size_ff <= GS_W'(1);
         fill_ff       <= '0;
         n_ff          <= '0;
         cnt_ff        <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         group_size_ff <= group_size_in;
         fill_ff       <= fill_in;
         n_ff          <= n_in;
         cnt_ff        <= cnt_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rev_ff       <= rev_in;
      end_ff       <= end_in;
      pend_last_ff <= pend_last_in;
      pend_end_ff  <= pend_end_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_value      = rsp_value_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_out_stream_end = rsp_end_ff;

   // checks
   `SBR_ASSERT_IMP(a_fill_in_range, 1'b1, fill_ff < FILL_W'(MAX_GROUP))
   `SBR_ASSERT_IMP(a_drain_nonempty, state_ff == ST_DRAIN, (n_ff != '0) && (cnt_ff <= n_ff))
   `SBR_ASSERT_NXT(a_pend_holds, pend_ff && !out_free, pend_ff && $stable(ram_q))
   `SBR_ASSERT_IMP(a_end_is_last, rsp_valid_ff && rsp_end_ff, rsp_last_ff)

endmodule

FILE: src/sbr_group_ram.sv
// Group store: one write port, one read port with registered read data.
module sbr_group_ram
   import sbr_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [IDX_W-1:0]         rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem_ff [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/stream_block_reverser_tb.sv
// Self-checking testbench for the stream block reverser: directed and random streams.
module stream_block_reverser_tb
   import sbr_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_GROUP    = 16;
   // readout of a full group plus margin
   localparam int DRAIN_CYCLES = MAX_GROUP + 8;
   localparam int RAND_ITEMS   = 34;
   localparam logic [CSR_ADDR_W-1:0] GS_ADDR = {REG_GROUP_SIZE, 2'b00};

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last_of_run;
      logic                     stream_end;
   } reorder_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [DATA_W-1:0] req_item_value;
   logic                     req_stream_end;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_out_value;
   logic                     rsp_last_of_run;
   logic                     rsp_out_stream_end;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_W-1:0]    paddr;
   logic [CSR_DATA_W-1:0]    pwdata;
   logic [CSR_DATA_W-1:0]    prdata;
   logic                     pready;

   // predictor state
   logic [DATA_W-1:0]  group_buf [MAX_GROUP];
   int unsigned        group_fill;
   logic [GS_W-1:0]    group_size_shadow;
   reorder_result_type reorder_q [$];

   int send_idle_pct;
   int recv_idle_pct;
   int mismatch_count;

   stream_block_reverser #(
      .MAX_GROUP (MAX_GROUP)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_item_value     (req_item_value),
      .req_stream_end     (req_stream_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_value      (rsp_out_value),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_out_stream_end (rsp_out_stream_end),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // clock, 20 ns period
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // receiver backpressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // buffer one value and queue the results it releases
   function automatic void predict_reorder(input logic signed [DATA_W-1:0] value,
                                           input logic ending);
      int unsigned k;
      int unsigned n;
      bit          reverse;
      reorder_result_type r;
      k = group_size_shadow;
      if (k == 0) k = 1;
      if (k > MAX_GROUP) k = MAX_GROUP;
      if (group_fill < MAX_GROUP) begin
         group_buf[group_fill] = value;
         group_fill++;
      end
      if (group_fill >= k) reverse = 1'b1;
      else if (ending) reverse = 1'b0;
      else return;
      n = group_fill;
      for (int unsigned i = 0; i < n; i++) begin
         r.value       = group_buf[reverse ? (n - 1 - i) : i];
         r.last_of_run = (i + 1 == n);
         r.stream_end  = (i + 1 == n) && ending;
         reorder_q.push_back(r);
      end
      group_fill = 0;
   endfunction

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      reorder_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (reorder_q.size() == 0) begin
            $error("unexpected result: out_value %0d", rsp_out_value);
            mismatch_count++;
         end else begin
            exp_r = reorder_q.pop_front();
            if (rsp_out_value !== exp_r.value) begin
               $error("out_value: expected %0d, actual %0d", exp_r.value, rsp_out_value);
               mismatch_count++;
            end
            if (rsp_last_of_run !== exp_r.last_of_run) begin
               $error("last_of_run: expected %0b, actual %0b",
                      exp_r.last_of_run, rsp_last_of_run);
               mismatch_count++;
            end
            if (rsp_out_stream_end !== exp_r.stream_end) begin
               $error("out_stream_end: expected %0b, actual %0b",
                      exp_r.stream_end, rsp_out_stream_end);
               mismatch_count++;
            end
         end
      end
   end

   // one input transfer, with random sender gaps before it
   task automatic send_value(input logic signed [DATA_W-1:0] value, input logic ending);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_item_value = value;
      req_stream_end = ending;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_reorder(value, ending);
   endtask

   // sender goes quiet until every queued result has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (reorder_q.size() != 0) @(posedge clock);
   endtask

   // block fully idle: drained plus readout margin
   task automatic settle_idle();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write group_size, then read it back
   task automatic write_group_size(input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    = 1'b1;
      pwrite  = 1'b1;
      penable = 1'b0;
      paddr   = GS_ADDR;
      pwdata  = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      group_size_shadow = data[GS_W-1:0];
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== CSR_DATA_W'(group_size_shadow)) begin
         $error("group_size readback: expected %0d, actual %0d",
                group_size_shadow, prdata);
         mismatch_count++;
      end
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   // random payload, weighted toward the extremes
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(11))
         0: pick_value = 32'sh7FFF_FFFF;
         1: pick_value = 32'sh8000_0000;
         2: pick_value = '0;
         3: pick_value = '1;
         default: pick_value = $urandom();
      endcase
   endfunction

   // reset value of group_size is 1: stream passes through
   task automatic test_pass_through();
      send_value(32'sh7FFF_FFFF, 1'b0);
      send_value(32'sh8000_0000, 1'b0);
      send_value('0, 1'b0);
      send_value('1, 1'b1);
   endtask

   // stream ends exactly on a full group: emitted reversed
   task automatic test_full_group_on_end();
      settle_idle();
      write_group_size(3);
      for (int i = 0; i < 6; i++) send_value(pick_value(), i == 5);
   endtask

   // incomplete group at the end of the stream keeps arrival order
   task automatic test_partial_group_at_end();
      settle_idle();
      write_group_size(5);
      for (int i = 0; i < 3; i++) send_value(pick_value(), i == 2);
   endtask

   // size zero acts as size one
   task automatic test_group_size_zero();
      settle_idle();
      write_group_size(32'hFFFF_FFE0);
      send_value(pick_value(), 1'b0);
      send_value(pick_value(), 1'b1);
   endtask

   // size dropped below the buffered count while a group is filling
   task automatic test_size_lowered_mid_group();
      settle_idle();
      write_group_size(6);
      for (int i = 0; i < 4; i++) send_value(pick_value(), 1'b0);
      settle_idle();
      write_group_size(2);
      send_value(pick_value(), 1'b0);
   endtask

   // random streams across sizes (saturating ones included) and idle modes
   task automatic test_random_streams();
      logic [GS_W-1:0] sizes [3][4];
      logic [CSR_DATA_W-1:0] data;
      sizes[0] = '{5'd1, 5'd16, 5'd31, 5'd0};
      sizes[1] = '{5'd7, 5'd3, 5'd17, 5'd12};
      sizes[2] = '{GS_W'($urandom_range(16, 1)), 5'd2, GS_W'($urandom_range(31)), 5'd5};
      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin send_idle_pct = 30; recv_idle_pct = 49; end
            1: begin send_idle_pct = 49; recv_idle_pct = 30; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int s = 0; s < 4; s++) begin
            settle_idle();
            data = $urandom_range(1) ? ($urandom() & ~32'h1F) : '0;
            write_group_size(data | CSR_DATA_W'(sizes[m][s]));
            for (int i = 0; i < RAND_ITEMS; i++) begin
               if ($urandom_range(39) == 0) wait_drained();
               send_value(pick_value(), $urandom_range(11) == 0);
            end
         end
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_item_value    = '0;
      req_stream_end    = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      send_idle_pct     = 30;
      recv_idle_pct     = 49;
      mismatch_count    = 0;
      group_fill        = 0;
      group_size_shadow = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_pass_through();
      test_full_group_on_end();
      test_partial_group_at_end();
      test_group_size_zero();
      test_size_lowered_mid_group();
      test_random_streams();

      settle_idle();
      if (reorder_q.size() != 0) begin
         $error("out_value: expected %0d more results, actual none", reorder_q.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/sbr_pkg.sv
src/sbr_group_ram.sv
src/stream_block_reverser.sv
tb/stream_block_reverser_tb.sv
